// File: rtl/core/anp_pkg.sv
`default_nettype none

package anp_pkg;

	localparam logic [1:0] KIND_U32 = 2'd0;
	localparam logic [1:0] KIND_S32 = 2'd1;
	localparam logic [1:0] KIND_U8  = 2'd2;

	localparam logic [7:0] CHAR_END     = 8'h00;
	localparam logic [7:0] CHAR_MINUS   = 8'h2D;
	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_UP_A    = 8'h41;
	localparam logic [7:0] CHAR_UP_F    = 8'h46;
	localparam logic [7:0] CHAR_LOW_A   = 8'h61;
	localparam logic [7:0] CHAR_LOW_F   = 8'h66;
	localparam logic [7:0] CHAR_UP_X    = 8'h58;
	localparam logic [7:0] CHAR_LOW_X   = 8'h78;

	localparam logic [3:0] POS_MAX = 4'd15;

	typedef struct packed {
		logic [7:0] character;
		logic [1:0] value_kind;
	} item_t;

	typedef struct packed {
		logic        emit;
		logic [31:0] number;
		logic        bad_text;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/anp_char_if.sv
`default_nettype none

interface anp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic [1:0] value_kind;

	modport source (output valid, output character, output value_kind, input ready);
	modport sink (input valid, input character, input value_kind, output ready);
endinterface

`default_nettype wire

// File: rtl/core/anp_num_if.sv
`default_nettype none

interface anp_num_if;
	logic        valid;
	logic        ready;
	logic [31:0] number;
	logic        bad_text;

	modport source (output valid, output number, output bad_text, input ready);
	modport sink (input valid, input number, input bad_text, output ready);
endinterface

`default_nettype wire

// File: rtl/core/anp_in_stage.sv
`default_nettype none

module anp_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	anp_char_if.sink           text,
	input  wire logic          out_free,
	output anp_pkg::item_t     item,
	output logic               fire
);
	import anp_pkg::*;

	logic  valid_s1;
	item_t item_s1;

	// a terminator may only move on when the result register can take it
	assign fire       = valid_s1 && ((item_s1.character != CHAR_END) || out_free);
	assign text.ready = !valid_s1 || fire;
	assign item       = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text.ready) begin
			valid_s1 <= text.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text.valid && text.ready) begin
			item_s1.character  <= text.character;
			item_s1.value_kind <= text.value_kind;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/anp_step.sv
`default_nettype none

module anp_step (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire anp_pkg::item_t item,
	input  wire logic           fire,
	output anp_pkg::result_t    res
);
	import anp_pkg::*;

	logic [31:0] acc_q, acc_d;
	logic [3:0]  pos_q, pos_d;
	logic [1:0]  kind_q, kind_d;
	logic        hex_q, hex_d;
	logic        lz_q, lz_d;
	logic        minus_q, minus_d;
	logic        failed_q, failed_d;

	// 16 marks a character that is no hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			v = 5'(c - CHAR_ZERO);
		end else if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
			v = 5'(c - CHAR_UP_A + 8'd10);
		end else if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
			v = 5'(c - CHAR_LOW_A + 8'd10);
		end
		return v;
	endfunction

	logic [1:0]  kind;
	logic [7:0]  c;
	logic [4:0]  hex_d_val;
	logic [3:0]  base;
	logic [3:0]  rel_pos;
	logic        is_dec;
	logic        bad;

	always_comb begin
		c         = item.character;
		kind      = (pos_q == 4'd0) ? item.value_kind : kind_q;
		base      = {3'd0, minus_q};
		rel_pos   = pos_q - base;
		hex_d_val = hex_value(c);
		is_dec    = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

		acc_d    = acc_q;
		pos_d    = pos_q;
		kind_d   = kind;
		hex_d    = hex_q;
		lz_d     = lz_q;
		minus_d  = minus_q;
		failed_d = failed_q;

		bad = failed_q || (kind > KIND_U8) ||
			((kind == KIND_U8) && !hex_q && (acc_q > 32'd255));

		res.emit     = fire && (c == CHAR_END);
		res.bad_text = bad;
		if (bad) begin
			res.number = 32'd0;
		end else if (kind == KIND_S32 && minus_q) begin
			res.number = 32'd0 - acc_q;
		end else if (kind == KIND_U8) begin
			res.number = {24'd0, acc_q[7:0]};
		end else begin
			res.number = acc_q;
		end

		if (c == CHAR_END) begin
			acc_d    = 32'd0;
			pos_d    = 4'd0;
			kind_d   = KIND_U32;
			hex_d    = 1'b0;
			lz_d     = 1'b0;
			minus_d  = 1'b0;
			failed_d = 1'b0;
		end else begin
			if (pos_q != POS_MAX) begin
				pos_d = pos_q + 4'd1;
			end
			if (!failed_q) begin
				if (kind > KIND_U8) begin
					failed_d = 1'b1;
				end else if (kind == KIND_S32 && pos_q == 4'd0 && c == CHAR_MINUS) begin
					minus_d = 1'b1;
				end else if (!hex_q && lz_q && pos_q == base + 4'd1 &&
					(c == CHAR_LOW_X || c == CHAR_UP_X)) begin
					hex_d = 1'b1;
				end else if (hex_q) begin
					if ((kind == KIND_S32 && rel_pos >= 4'd10) ||
						(kind == KIND_U8 && pos_q >= 4'd4) || hex_d_val[4]) begin
						failed_d = 1'b1;
					end else begin
						acc_d = {acc_q[27:0], 4'd0} + {28'd0, hex_d_val[3:0]};
					end
				end else begin
					if ((kind == KIND_U8 && pos_q >= 4'd3) || !is_dec) begin
						failed_d = 1'b1;
					end else begin
						if (pos_q == base && c == CHAR_ZERO) begin
							lz_d = 1'b1;
						end
						// times ten as two shifts
						acc_d = {acc_q[28:0], 3'd0} + {acc_q[30:0], 1'b0} +
							{28'd0, c[3:0]};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= 32'd0;
			pos_q    <= 4'd0;
			kind_q   <= KIND_U32;
			hex_q    <= 1'b0;
			lz_q     <= 1'b0;
			minus_q  <= 1'b0;
			failed_q <= 1'b0;
		end else if (fire) begin
			acc_q    <= acc_d;
			pos_q    <= pos_d;
			kind_q   <= kind_d;
			hex_q    <= hex_d;
			lz_q     <= lz_d;
			minus_q  <= minus_d;
			failed_q <= failed_d;
		end
	end

	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit && res.bad_text |-> res.number == 32'd0)
		else $error("rejected text with nonzero number");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		res.emit |=> pos_q == 4'd0 && acc_q == 32'd0 && !failed_q && !hex_q)
		else $error("state not cleared after terminator");

	a_hex_needs_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hex_q |-> lz_q)
		else $error("hex mode without leading zero");

	a_pos_grows: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !res.emit && pos_q != POS_MAX |=> pos_q == $past(pos_q) + 4'd1)
		else $error("character position did not advance");

endmodule

`default_nettype wire

// File: rtl/core/anp_out_stage.sv
`default_nettype none

module anp_out_stage (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire anp_pkg::result_t res,
	output logic                  out_free,
	anp_num_if.source             result
);
	import anp_pkg::*;

	logic        valid_q;
	logic [31:0] number_q;
	logic        bad_q;

	assign out_free        = !valid_q || result.ready;
	assign result.valid    = valid_q;
	assign result.number   = number_q;
	assign result.bad_text = bad_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (res.emit) begin
			number_q <= res.number;
			bad_q    <= res.bad_text;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/ascii_number_parser_top.sv
// Streaming text-to-number converter. One character is taken per transfer on
// the text channel, a zero character ends the text, and the terminator yields
// one transfer on the result channel with the number and a reject flag; other
// characters yield nothing. A character can be taken in every cycle unless
// the input stalls: it sits in the input register while the update (a
// shift-add by ten or sixteen into the accumulator) runs, and a terminator
// passes from the input register into the result register, which offers
// the result. The input only stalls when a terminator meets a result that
// has not yet been taken.
`default_nettype none

module ascii_number_parser_top (
	input  wire logic clk,
	input  wire logic arst_n,
	anp_char_if.sink  text,
	anp_num_if.source result
);
	import anp_pkg::*;

	item_t   item;
	result_t res;
	logic    fire;
	logic    out_free;

	anp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.text     (text),
		.out_free (out_free),
		.item     (item),
		.fire     (fire)
	);

	anp_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.fire   (fire),
		.res    (res)
	);

	anp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.res      (res),
		.out_free (out_free),
		.result   (result)
	);

endmodule

`default_nettype wire
